FILE: rtl/ccsp_pkg.sv
// Shared definitions for the capped cylinder surface projection block.
// Configuration register map. No dependencies.
package ccsp_pkg;

    localparam int CFG_ADDR_W = 2;

    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;

    localparam t_cfg_addr CFG_HALF_LENGTH = 2'd0;
    localparam t_cfg_addr CFG_CYL_RADIUS  = 2'd1;

endpackage

FILE: rtl/capped_cylinder_surface_projection.sv
// Closest point on an X-aligned flat-capped cylinder surface, fixed point.
// Fully pipelined; throughput one transaction per cycle while the output is not stalled.
// The root and divide units retire one bit per stage and set the depth.
// The whole pipeline holds when the output is stalled.
// Synchronous active-low reset clears valid bits and both size registers.
// Depends on ccsp_pkg, ccsp_isqrt, ccsp_div.
module capped_cylinder_surface_projection #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  ccsp_pkg::t_cfg_addr           i_cfg_addr,
    input  logic [COORD_WIDTH-2:0]        i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_proj_x,
    output logic signed [COORD_WIDTH-1:0] o_proj_y,
    output logic signed [COORD_WIDTH-1:0] o_proj_z
);

    localparam int CW  = COORD_WIDTH;
    localparam int ISB = 3 + 3*CW + 1;
    localparam int DSB = 3 + 3*CW + 2;

    logic          en;
    logic [CW-2:0] r_half_length;
    logic [CW-2:0] r_cyl_radius;
    logic [CW-1:0] h;
    logic [CW-1:0] r;

    assign h  = {1'b0, r_half_length};
    assign r  = {1'b0, r_cyl_radius};
    assign en = !o_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_length <= '0;
            r_cyl_radius  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ccsp_pkg::CFG_HALF_LENGTH: r_half_length <= i_cfg_wdata;
                ccsp_pkg::CFG_CYL_RADIUS:  r_cyl_radius  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage A: sign and magnitude (most negative maps to 2^(CW-1))
    logic          r_a_vld;
    logic [2:0]    r_a_neg;
    logic [CW-1:0] r_a_mx, r_a_my, r_a_mz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_neg <= {i_pos_z[CW-1], i_pos_y[CW-1], i_pos_x[CW-1]};
            r_a_mx  <= i_pos_x[CW-1] ? -i_pos_x : i_pos_x;
            r_a_my  <= i_pos_y[CW-1] ? -i_pos_y : i_pos_y;
            r_a_mz  <= i_pos_z[CW-1] ? -i_pos_z : i_pos_z;
        end
    end

    // stage B: squares
    logic            r_b_vld;
    logic [2:0]      r_b_neg;
    logic [CW-1:0]   r_b_mx, r_b_my, r_b_mz;
    logic [2*CW-1:0] r_b_yy, r_b_zz;
    logic [2*CW-1:0] r_b_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_neg <= r_a_neg;
            r_b_mx  <= r_a_mx;
            r_b_my  <= r_a_my;
            r_b_mz  <= r_a_mz;
            r_b_yy  <= r_a_my * r_a_my;
            r_b_zz  <= r_a_mz * r_a_mz;
            r_b_rr  <= r * r;
        end
    end

    // stage C: radial square sum and outside-radius test
    logic            r_c_vld;
    logic [2*CW-1:0] r_c_s;
    logic [ISB-1:0]  r_c_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_s  <= r_b_yy + r_b_zz;
            r_c_sb <= {(r_b_yy + r_b_zz) > r_b_rr, r_b_neg, r_b_mx, r_b_my, r_b_mz};
        end
    end

    logic           sq_vld;
    logic [CW-1:0]  sq_n;
    logic [ISB-1:0] sq_sb;

    ccsp_isqrt #(.CW(CW), .SBW(ISB)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_vld),
        .i_rad   (r_c_s),
        .i_sb    (r_c_sb),
        .o_valid (sq_vld),
        .o_root  (sq_n),
        .o_sb    (sq_sb)
    );

    // stage D: pick cap or wall, form scaled numerators
    logic          d_out;
    logic [2:0]    d_neg;
    logic [CW-1:0] d_mx, d_my, d_mz;
    logic          d_beyond;
    logic          d_cap;
    logic          d_side;

    assign {d_out, d_neg, d_mx, d_my, d_mz} = sq_sb;
    assign d_beyond = d_mx > h;
    // inside: nearer surface wins; on the axis there is no radial direction
    assign d_cap  = d_beyond ||
                    (!d_out && (((h - d_mx) < (r - sq_n)) || (sq_n == '0)));
    assign d_side = d_out || !d_cap;

    logic            r_d_vld;
    logic [2*CW-1:0] r_d_num_y, r_d_num_z;
    logic [CW-1:0]   r_d_n;
    logic [DSB-1:0]  r_d_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_num_y <= d_my * r;
            r_d_num_z <= d_mz * r;
            r_d_n     <= sq_n;
            r_d_sb    <= {d_cap, d_side, d_neg, d_mx, d_my, d_mz};
        end
    end

    logic           dv_vld;
    logic [CW-1:0]  dv_qy, dv_qz, dv_ry, dv_rz, dv_den;
    logic [DSB-1:0] dv_sb;

    ccsp_div #(.CW(CW), .SBW(DSB)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_vld),
        .i_num_y (r_d_num_y),
        .i_num_z (r_d_num_z),
        .i_den   (r_d_n),
        .i_sb    (r_d_sb),
        .o_valid (dv_vld),
        .o_quo_y (dv_qy),
        .o_quo_z (dv_qz),
        .o_rem_y (dv_ry),
        .o_rem_z (dv_rz),
        .o_den   (dv_den),
        .o_sb    (dv_sb)
    );

    // stage E: round half away, select, restore sign
    logic          e_cap, e_side;
    logic [2:0]    e_neg;
    logic [CW-1:0] e_mx, e_my, e_mz;
    logic [CW-1:0] e_qy, e_qz;
    logic [CW-1:0] e_res_x, e_res_y, e_res_z;

    assign {e_cap, e_side, e_neg, e_mx, e_my, e_mz} = dv_sb;
    assign e_qy = dv_qy + CW'({dv_ry, 1'b0} >= {1'b0, dv_den});
    assign e_qz = dv_qz + CW'({dv_rz, 1'b0} >= {1'b0, dv_den});
    assign e_res_x = e_cap  ? h    : e_mx;
    assign e_res_y = e_side ? e_qy : e_my;
    assign e_res_z = e_side ? e_qz : e_mz;

    logic r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_proj_x <= e_neg[0] ? -e_res_x : e_res_x;
            o_proj_y <= e_neg[1] ? -e_res_y : e_res_y;
            o_proj_z <= e_neg[2] ? -e_res_z : e_res_z;
        end
    end

    assign o_valid = r_out_vld;

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("input taken while output stalled");

    a_empty_output_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("not ready with empty output stage");

    a_reset_clears_output: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");
`endif

endmodule

FILE: rtl/ccsp_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Carries a sideband word alongside. No package dependencies.
module ccsp_isqrt #(
    parameter int CW  = 32,
    parameter int SBW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*CW-1:0]   i_rad,
    input  logic [SBW-1:0]    i_sb,
    output logic              o_valid,
    output logic [CW-1:0]     o_root,
    output logic [SBW-1:0]    o_sb
);

    logic            r_vld  [1:CW];
    logic [2*CW-1:0] r_rad  [1:CW];
    logic [CW+1:0]   r_rem  [1:CW];
    logic [CW-1:0]   r_root [1:CW];
    logic [SBW-1:0]  r_sb   [1:CW];

    for (genvar k = 0; k < CW; k++) begin : g_stage
        logic            vin;
        logic [2*CW-1:0] rad;
        logic [CW+1:0]   rem;
        logic [CW-1:0]   root;
        logic [SBW-1:0]  sb;
        logic [CW+1:0]   rsh;
        logic [CW+1:0]   trial;

        if (k == 0) begin : g_first
            assign vin  = i_valid;
            assign rad  = i_rad;
            assign rem  = '0;
            assign root = '0;
            assign sb   = i_sb;
        end else begin : g_next
            assign vin  = r_vld[k];
            assign rad  = r_rad[k];
            assign rem  = r_rem[k];
            assign root = r_root[k];
            assign sb   = r_sb[k];
        end

        // bring down the next two radicand bits, try root*4+1
        assign rsh   = {rem[CW-1:0], rad[2*CW-1-2*k -: 2]};
        assign trial = {root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k+1] <= rad;
                r_sb[k+1]  <= sb;
                if (rsh >= trial) begin
                    r_rem[k+1]  <= rsh - trial;
                    r_root[k+1] <= {root[CW-2:0], 1'b1};
                end else begin
                    r_rem[k+1]  <= rsh;
                    r_root[k+1] <= {root[CW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_vld[CW];
    assign o_root  = r_root[CW];
    assign o_sb    = r_sb[CW];

endmodule

FILE: rtl/ccsp_div.sv
// Pipelined two-lane restoring divider, one quotient bit per stage.
// Quotient must fit CW bits. No package dependencies.
module ccsp_div #(
    parameter int CW  = 32,
    parameter int SBW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*CW-1:0]   i_num_y,
    input  logic [2*CW-1:0]   i_num_z,
    input  logic [CW-1:0]     i_den,
    input  logic [SBW-1:0]    i_sb,
    output logic              o_valid,
    output logic [CW-1:0]     o_quo_y,
    output logic [CW-1:0]     o_quo_z,
    output logic [CW-1:0]     o_rem_y,
    output logic [CW-1:0]     o_rem_z,
    output logic [CW-1:0]     o_den,
    output logic [SBW-1:0]    o_sb
);

    logic           r_vld [1:CW];
    logic [CW-1:0]  r_den [1:CW];
    logic [SBW-1:0] r_sb  [1:CW];
    logic [CW-1:0]  r_rem [1:CW][0:1];
    logic [CW-1:0]  r_lo  [1:CW][0:1];
    logic [CW-1:0]  r_quo [1:CW][0:1];

    for (genvar k = 0; k < CW; k++) begin : g_stage
        logic           vin;
        logic [CW-1:0]  den;
        logic [SBW-1:0] sb;

        if (k == 0) begin : g_first
            assign vin = i_valid;
            assign den = i_den;
            assign sb  = i_sb;
        end else begin : g_next
            assign vin = r_vld[k];
            assign den = r_den[k];
            assign sb  = r_sb[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k+1] <= den;
                r_sb[k+1]  <= sb;
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [CW-1:0] rem;
            logic [CW-1:0] lo;
            logic [CW-1:0] quo;
            logic [CW:0]   t;
            logic [CW:0]   diff;
            logic          ge;

            if (k == 0) begin : g_first
                // high half is already below the divisor
                assign rem = (l == 0) ? i_num_y[2*CW-1:CW] : i_num_z[2*CW-1:CW];
                assign lo  = (l == 0) ? i_num_y[CW-1:0] : i_num_z[CW-1:0];
                assign quo = '0;
            end else begin : g_next
                assign rem = r_rem[k][l];
                assign lo  = r_lo[k][l];
                assign quo = r_quo[k][l];
            end

            assign t    = {rem, lo[CW-1]};
            assign diff = t - {1'b0, den};
            assign ge   = (t >= {1'b0, den});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1][l] <= ge ? diff[CW-1:0] : t[CW-1:0];
                    r_lo[k+1][l]  <= {lo[CW-2:0], 1'b0};
                    r_quo[k+1][l] <= {quo[CW-2:0], ge};
                end
            end
        end
    end

    assign o_valid = r_vld[CW];
    assign o_quo_y = r_quo[CW][0];
    assign o_quo_z = r_quo[CW][1];
    assign o_rem_y = r_rem[CW][0];
    assign o_rem_z = r_rem[CW][1];
    assign o_den   = r_den[CW];
    assign o_sb    = r_sb[CW];

endmodule
